FILE: src/rchpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hopping packet framer package
// Shared types, payload constants and the channel hopping table.
// ----------------------------------------------------------------------------
package rchpf_pkg;

    // Payload layout and protocol constants.
    localparam int          PKT_LEN    = 16;
    localparam logic [7:0]  BIND_FLAGS = 8'hC0;
    localparam logic [7:0]  TRIM_MID   = 8'h40;
    localparam logic [3:0]  LAST_INDEX = 4'd15;

    // Configuration register indexes.
    localparam logic [1:0]  REG_TX_ID_0 = 2'd0;
    localparam logic [1:0]  REG_TX_ID_1 = 2'd1;
    localparam logic [1:0]  REG_TX_ID_2 = 2'd2;

    // Control word handed to every cell of the shift line.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Four hopping rows of sixteen channels each.
    localparam logic [7:0] HOP_TABLE [4][16] = '{
        '{8'h27, 8'h1B, 8'h39, 8'h28, 8'h24, 8'h22, 8'h2E, 8'h36,
          8'h19, 8'h21, 8'h29, 8'h14, 8'h1E, 8'h12, 8'h2D, 8'h18},
        '{8'h2E, 8'h33, 8'h25, 8'h38, 8'h19, 8'h12, 8'h18, 8'h16,
          8'h2A, 8'h1C, 8'h1F, 8'h37, 8'h2F, 8'h23, 8'h34, 8'h10},
        '{8'h11, 8'h1A, 8'h35, 8'h24, 8'h28, 8'h18, 8'h25, 8'h2A,
          8'h32, 8'h2C, 8'h14, 8'h27, 8'h36, 8'h34, 8'h1C, 8'h17},
        '{8'h22, 8'h27, 8'h17, 8'h39, 8'h34, 8'h28, 8'h2B, 8'h1D,
          8'h18, 8'h2A, 8'h21, 8'h38, 8'h10, 8'h26, 8'h20, 8'h1F}
    };

endpackage

FILE: src/rchpf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift line cell
// Holds one payload byte; loads in parallel or takes its neighbor's byte.
// ----------------------------------------------------------------------------
module rchpf_cell (
    input  logic                aclk,
    input  rchpf_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          load_byte,
    input  logic [7:0]          shift_in,
    output logic [7:0]          byte_out
);
    import rchpf_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // A parallel load wins over a shift.
    always_comb begin
        data_next = data_reg;
        if (ctrl.load) begin
            data_next = load_byte;
        end else if (ctrl.shift) begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign byte_out = data_reg;

endmodule

FILE: src/rchpf_hop_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hop channel calculator
// Picks the hopping row and offset from the identity and looks up a channel.
// ----------------------------------------------------------------------------
module rchpf_hop_calc (
    input  logic [7:0] tx_id_0,
    input  logic [7:0] tx_id_1,
    input  logic [7:0] tx_id_2,
    input  logic [3:0] column,
    output logic [5:0] channel
);
    import rchpf_pkg::*;

    logic [7:0] id_sum;
    logic [7:0] step;
    logic [7:0] raw_ch;
    logic [7:0] fixed_ch;

    // The identity sum selects the row and a small offset.
    always_comb begin
        id_sum = tx_id_0 + tx_id_1 + tx_id_2;
        step   = {5'd0, id_sum[4:2]};
        raw_ch = HOP_TABLE[id_sum[1:0]][column] + step;
        // A channel on a multiple of sixteen is moved down by three.
        if (raw_ch[3:0] == 4'd0) begin
            fixed_ch = raw_ch - 8'd3;
        end else begin
            fixed_ch = raw_ch;
        end
        channel = fixed_ch[5:0];
    end

endmodule

FILE: src/rc_hopping_packet_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hopping RC packet framer
// Turns each stick command into a 16-byte radio payload, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one stick command word (throttle, yaw, pitch, roll,
//   flag_bits). The m_ channel returns sixteen words per command, bytes 0 to
//   15 in order, each tagged with its index and the packet's hop channel;
//   last_byte marks the checksum byte.
//   A command is held in a one-deep input buffer and loaded into a line of
//   sixteen byte cells that shifts one byte toward the output per accepted
//   word. The checksum is accumulated as bytes leave the line.
//   The shift line gives one byte per cycle while the receiver takes words;
//   the next packet loads in the same cycle as the checksum word leaves.
//   The transmitter identity is to be written through the APB port only
//   while idle; the user is bound by this, the block does not enforce it.
//   Reset clears the buffer, the busy flag, the identity and the hop counter.
//   When the receiver stalls, the current word holds and the line stops;
//   one further command can still be buffered.
// ----------------------------------------------------------------------------
module rc_hopping_packet_framer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_throttle,
    input  logic [7:0]  s_yaw,
    input  logic [7:0]  s_pitch,
    input  logic [7:0]  s_roll,
    input  logic [7:0]  s_flag_bits,
    // Payload channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic [3:0]  m_byte_index,
    output logic [5:0]  m_hop_channel,
    output logic        m_last_byte,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rchpf_pkg::*;

    // Configuration registers.
    logic [7:0] tx_id_0_reg, tx_id_0_next;
    logic [7:0] tx_id_1_reg, tx_id_1_next;
    logic [7:0] tx_id_2_reg, tx_id_2_next;

    // Input buffer.
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_throttle_reg, pend_yaw_reg, pend_pitch_reg, pend_roll_reg;
    logic [7:0] pend_flags_reg;

    // Output side state.
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic [5:0] chan_reg, chan_next;
    logic [4:0] hop_pos_reg, hop_pos_next;

    logic       s_fire;
    logic       m_fire;
    logic       line_free;
    logic       load_line;
    logic       cfg_write;
    logic       is_bind;
    logic [5:0] new_chan;
    cell_ctrl_t cell_ctrl;

    logic [7:0] load_bytes [PKT_LEN];
    logic [7:0] cell_bytes [PKT_LEN];

    // Handshakes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = !pend_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = busy_reg;
    assign m_fire    = m_valid && m_ready;
    assign line_free = !busy_reg || (m_fire && (idx_reg == LAST_INDEX));
    assign load_line = pend_valid_reg && line_free;

    assign cell_ctrl.load  = load_line;
    assign cell_ctrl.shift = m_fire;

    // Register writes; writes beyond the list are dropped.
    always_comb begin
        tx_id_0_next = tx_id_0_reg;
        tx_id_1_next = tx_id_1_reg;
        tx_id_2_next = tx_id_2_reg;
        if (cfg_write) begin
            case (paddr[3:2])
                REG_TX_ID_0: tx_id_0_next = pwdata[7:0];
                REG_TX_ID_1: tx_id_1_next = pwdata[7:0];
                REG_TX_ID_2: tx_id_2_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[3:2])
            REG_TX_ID_0: prdata = {24'd0, tx_id_0_reg};
            REG_TX_ID_1: prdata = {24'd0, tx_id_1_reg};
            REG_TX_ID_2: prdata = {24'd0, tx_id_2_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_id_0_reg <= 8'd0;
            tx_id_1_reg <= 8'd0;
            tx_id_2_reg <= 8'd0;
        end else begin
            tx_id_0_reg <= tx_id_0_next;
            tx_id_1_reg <= tx_id_1_next;
            tx_id_2_reg <= tx_id_2_next;
        end
    end

    // Input buffer fills on accept and empties when the line loads.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (load_line) begin
            pend_valid_next = 1'b0;
        end
        if (s_fire) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pend_throttle_reg <= s_throttle;
            pend_yaw_reg      <= s_yaw;
            pend_pitch_reg    <= s_pitch;
            pend_roll_reg     <= s_roll;
            pend_flags_reg    <= s_flag_bits;
        end
    end

    // Channel for the packet about to load.
    rchpf_hop_calc u_hop_calc (
        .tx_id_0 (tx_id_0_reg),
        .tx_id_1 (tx_id_1_reg),
        .tx_id_2 (tx_id_2_reg),
        .column  (hop_pos_reg[4:1]),
        .channel (new_chan)
    );

    // Payload image; the checksum slot is filled from the accumulator.
    assign is_bind = (pend_flags_reg == BIND_FLAGS);
    always_comb begin
        load_bytes[0]  = is_bind ? 8'd0 : pend_throttle_reg;
        load_bytes[1]  = is_bind ? 8'd0 : pend_yaw_reg;
        load_bytes[2]  = is_bind ? 8'd0 : pend_pitch_reg;
        load_bytes[3]  = is_bind ? 8'd0 : pend_roll_reg;
        load_bytes[4]  = is_bind ? 8'd0 : TRIM_MID;
        load_bytes[5]  = is_bind ? 8'd0 : TRIM_MID;
        load_bytes[6]  = is_bind ? 8'd0 : TRIM_MID;
        load_bytes[7]  = tx_id_0_reg;
        load_bytes[8]  = tx_id_1_reg;
        load_bytes[9]  = tx_id_2_reg;
        load_bytes[10] = 8'd0;
        load_bytes[11] = 8'd0;
        load_bytes[12] = 8'd0;
        load_bytes[13] = 8'd0;
        load_bytes[14] = pend_flags_reg;
        load_bytes[15] = 8'd0;
    end

    // Line of byte cells shifting toward cell zero.
    for (genvar g = 0; g < PKT_LEN; g++) begin : g_cell
        if (g == PKT_LEN - 1) begin : g_tail
            rchpf_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl),
                .load_byte (load_bytes[g]),
                .shift_in  (8'd0),
                .byte_out  (cell_bytes[g])
            );
        end else begin : g_body
            rchpf_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl),
                .load_byte (load_bytes[g]),
                .shift_in  (cell_bytes[g + 1]),
                .byte_out  (cell_bytes[g])
            );
        end
    end

    // Output sequencing, checksum accumulation and hop counter.
    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        chan_next    = chan_reg;
        hop_pos_next = hop_pos_reg;
        if (m_fire) begin
            idx_next = idx_reg + 4'd1;
            sum_next = sum_reg + cell_bytes[0];
            if (idx_reg == LAST_INDEX) begin
                busy_next = 1'b0;
            end
        end
        if (load_line) begin
            busy_next    = 1'b1;
            idx_next     = 4'd0;
            sum_next     = 8'd0;
            chan_next    = new_chan;
            hop_pos_next = hop_pos_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 4'd0;
            hop_pos_reg <= 5'd0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            hop_pos_reg <= hop_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        chan_reg <= chan_next;
    end

    // Result word.
    assign m_last_byte    = (idx_reg == LAST_INDEX);
    assign m_payload_byte = m_last_byte ? sum_reg : cell_bytes[0];
    assign m_byte_index   = idx_reg;
    assign m_hop_channel  = chan_reg;

endmodule

FILE: verif/rc_hopping_packet_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hopping RC packet framer testbench
// Sends stick commands and APB register accesses to the framer, works out the
// sixteen payload words that each command must produce (bytes, index, hop
// channel, last flag) and checks every word in order, while both channels
// idle at random in bursts.
// ----------------------------------------------------------------------------
module rc_hopping_packet_framer_top_tb;
    import rchpf_pkg::*;

    // Address slot past the last identity register; writes there are dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Hopping rows, kept apart from the package so that a bad table shows up.
    localparam logic [7:0] CHANNEL_ROWS [4][16] = '{
        '{8'h27, 8'h1B, 8'h39, 8'h28, 8'h24, 8'h22, 8'h2E, 8'h36,
          8'h19, 8'h21, 8'h29, 8'h14, 8'h1E, 8'h12, 8'h2D, 8'h18},
        '{8'h2E, 8'h33, 8'h25, 8'h38, 8'h19, 8'h12, 8'h18, 8'h16,
          8'h2A, 8'h1C, 8'h1F, 8'h37, 8'h2F, 8'h23, 8'h34, 8'h10},
        '{8'h11, 8'h1A, 8'h35, 8'h24, 8'h28, 8'h18, 8'h25, 8'h2A,
          8'h32, 8'h2C, 8'h14, 8'h27, 8'h36, 8'h34, 8'h1C, 8'h17},
        '{8'h22, 8'h27, 8'h17, 8'h39, 8'h34, 8'h28, 8'h2B, 8'h1D,
          8'h18, 8'h2A, 8'h21, 8'h38, 8'h10, 8'h26, 8'h20, 8'h1F}
    };

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] byte_index;
        logic [5:0] hop_channel;
        logic       last_byte;
    } payload_word_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_throttle = 8'h00;
    logic [7:0]  s_yaw = 8'h00;
    logic [7:0]  s_pitch = 8'h00;
    logic [7:0]  s_roll = 8'h00;
    logic [7:0]  s_flag_bits = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic [3:0]  m_byte_index;
    logic [5:0]  m_hop_channel;
    logic        m_last_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the framer state.
    logic [7:0]  tx_id [3] = '{8'h00, 8'h00, 8'h00};
    logic [4:0]  hop_count = 5'd0;

    payload_word_t expected_words [$];
    int errors = 0;
    int tx_gap_odds = 0;
    int rx_stall_odds = 0;
    int rx_hold = 0;

    rc_hopping_packet_framer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_throttle(s_throttle), .s_yaw(s_yaw), .s_pitch(s_pitch),
        .s_roll(s_roll), .s_flag_bits(s_flag_bits),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_payload_byte(m_payload_byte), .m_byte_index(m_byte_index),
        .m_hop_channel(m_hop_channel), .m_last_byte(m_last_byte),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("rc_hopping_packet_framer_top regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    // Channel of the packet at a hop position, from the current identity.
    function automatic logic [5:0] hop_channel_for(input logic [4:0] position);
        logic [7:0] id_sum;
        logic [7:0] offset;
        logic [7:0] chan;
        id_sum = tx_id[0] + tx_id[1] + tx_id[2];
        offset = (id_sum & 8'h1E) >> 2;
        chan = CHANNEL_ROWS[id_sum[1:0]][position[4:1]] + offset;
        if (chan[3:0] == 4'h0) begin
            chan = chan - 8'd3;
        end
        return chan[5:0];
    endfunction

    // Builds the payload of one accepted command and queues its sixteen words.
    task automatic frame_packet(input logic [7:0] throttle, yaw, pitch, roll, flags);
        logic [7:0]    packet [PKT_LEN];
        logic [7:0]    checksum;
        logic [5:0]    chan;
        payload_word_t word;
        if (flags == BIND_FLAGS) begin
            for (int i = 0; i < 7; i++) packet[i] = 8'h00;
        end else begin
            packet[0] = throttle;
            packet[1] = yaw;
            packet[2] = pitch;
            packet[3] = roll;
            packet[4] = TRIM_MID;
            packet[5] = TRIM_MID;
            packet[6] = TRIM_MID;
        end
        packet[7] = tx_id[0];
        packet[8] = tx_id[1];
        packet[9] = tx_id[2];
        for (int i = 10; i < 14; i++) packet[i] = 8'h00;
        packet[14] = flags;
        checksum = 8'h00;
        for (int i = 0; i < 15; i++) checksum = checksum + packet[i];
        packet[15] = checksum;
        chan = hop_channel_for(hop_count);
        hop_count = hop_count + 5'd1;
        for (int i = 0; i < PKT_LEN; i++) begin
            word.payload_byte = packet[i];
            word.byte_index   = 4'(i);
            word.hop_channel  = chan;
            word.last_byte    = (4'(i) == LAST_INDEX);
            expected_words.push_back(word);
        end
    endtask

    // Presents one command word, with an optional gap first, and waits for it
    // to be taken. Valid stays high afterwards so back-to-back words need no
    // second assignment in the same step.
    task automatic send_command(input logic [7:0] throttle, yaw, pitch, roll, flags);
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_throttle  <= throttle;
        s_yaw       <= yaw;
        s_pitch     <= pitch;
        s_roll      <= roll;
        s_flag_bits <= flags;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_packet(throttle, yaw, pitch, roll, flags);
    endtask

    // Holds off the sender until every queued word has come back.
    task automatic wait_for_payloads();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic write, input logic [1:0] index,
                                input logic [31:0] data, output logic [31:0] read_data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        read_data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        logic [31:0] unused;
        apb_transfer(1'b1, index, data, unused);
        if (index <= REG_TX_ID_2) begin
            tx_id[index] = data[7:0];
        end
    endtask

    task automatic read_check(input logic [1:0] index);
        logic [31:0] value;
        apb_transfer(1'b0, index, 32'h0, value);
        if (value !== {24'h0, tx_id[index]}) begin
            report_mismatch($sformatf("register %0d read %0h expected %0h",
                                      index, value, tx_id[index]));
        end
    endtask

    task automatic write_identity(input logic [7:0] id0, id1, id2);
        write_reg(REG_TX_ID_0, {24'($urandom), id0});
        write_reg(REG_TX_ID_1, {24'($urandom), id1});
        write_reg(REG_TX_ID_2, {24'($urandom), id2});
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // Bind, one bit away from bind, or anything.
    function automatic logic [7:0] rand_flags();
        case ($urandom_range(0, 3))
            0: begin
                return BIND_FLAGS;
            end
            1: begin
                return BIND_FLAGS ^ (8'h01 << $urandom_range(0, 7));
            end
            default: begin
                return rand_byte();
            end
        endcase
    endfunction

    task automatic send_random_command();
        send_command(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_flags());
    endtask

    // Reset values, wide write data and the unused address.
    task automatic test_register_access();
        for (int i = REG_TX_ID_0; i <= REG_TX_ID_2; i++) read_check(2'(i));
        write_reg(REG_TX_ID_0, 32'hDEAD_BEA5);
        write_reg(REG_TX_ID_1, 32'h0000_015A);
        write_reg(REG_TX_ID_2, 32'hFFFF_FF3C);
        for (int i = REG_TX_ID_0; i <= REG_TX_ID_2; i++) read_check(2'(i));
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        for (int i = REG_TX_ID_0; i <= REG_TX_ID_2; i++) read_check(2'(i));
    endtask

    // Stick and flag extremes under the lowest and highest identity.
    task automatic test_payload_fields();
        tx_gap_odds   = 4;
        rx_stall_odds = 4;
        write_identity(8'h00, 8'h00, 8'h00);
        send_command(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_command(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(8'h80, 8'h7F, 8'h80, 8'h7F, 8'h01);
        wait_for_payloads();
        write_identity(8'hFF, 8'hFF, 8'hFF);
        send_command(8'h7F, 8'h80, 8'h7F, 8'h80, 8'h3F);
        send_command(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA);
    endtask

    // Only the exact bind value clears the sticks and trims.
    task automatic test_bind_flags();
        send_command(8'hFF, 8'hFF, 8'hFF, 8'hFF, BIND_FLAGS);
        send_command(8'h12, 8'h34, 8'h56, 8'h78, BIND_FLAGS | 8'h01);
        send_command(8'h12, 8'h34, 8'h56, 8'h78, BIND_FLAGS & 8'h80);
        send_command(8'h12, 8'h34, 8'h56, 8'h78, BIND_FLAGS & 8'h40);
        send_command(8'h9A, 8'hBC, 8'hDE, 8'hF0, BIND_FLAGS | 8'h20);
        send_command(8'h00, 8'h00, 8'h00, 8'h00, BIND_FLAGS);
    endtask

    // A new identity moves the channel from the very next command.
    task automatic test_identity_change();
        wait_for_payloads();
        write_identity(8'h09, 8'h00, 8'h00);
        send_command(8'h21, 8'h43, 8'h65, 8'h87, 8'h00);
        send_command(8'h21, 8'h43, 8'h65, 8'h87, BIND_FLAGS);
        wait_for_payloads();
        write_identity(8'h00, 8'h00, 8'h01);
        send_command(8'hA9, 8'hCB, 8'hED, 8'h0F, 8'h10);
        send_command(8'hA9, 8'hCB, 8'hED, 8'h0F, 8'h10);
    endtask

    // Phases of random commands, each under its own identity and idle mix;
    // the sender drains the framer before every identity change.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++) begin
            wait_for_payloads();
            case (phase)
                0: begin
                    write_identity(8'hFF, 8'hFF, 8'hFF);
                end
                1: begin
                    write_identity(8'h00, 8'h00, 8'h00);
                end
                default: begin
                    write_identity(rand_byte(), rand_byte(), rand_byte());
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_UNUSED, $urandom);
            end
            case ($urandom_range(0, 2))
                0: begin
                    tx_gap_odds = 0;
                end
                1: begin
                    tx_gap_odds = 3;
                end
                default: begin
                    tx_gap_odds = 10;
                end
            endcase
            case ($urandom_range(0, 2))
                0: begin
                    rx_stall_odds = 0;
                end
                1: begin
                    rx_stall_odds = 3;
                end
                default: begin
                    rx_stall_odds = 10;
                end
            endcase
            repeat (34) send_random_command();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        wait_for_payloads();
        tx_gap_odds   = 0;
        rx_stall_odds = 0;
        write_identity(rand_byte(), rand_byte(), rand_byte());
        repeat (20) send_random_command();
    endtask

    // Receiver stalls in random bursts.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
            rx_hold = $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned got, want, index);
        if (got != want) begin
            report_mismatch($sformatf("byte %0d %s got %0h expected %0h",
                                      index, name, got, want));
        end
    endtask

    // Every accepted word is compared against the oldest queued word.
    always @(posedge aclk) begin : check_words
        payload_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word with no packet pending, index %0d",
                                          m_byte_index));
            end else begin
                want = expected_words.pop_front();
                check_field("payload_byte", 32'(m_payload_byte), 32'(want.payload_byte),
                            32'(want.byte_index));
                check_field("byte_index", 32'(m_byte_index), 32'(want.byte_index),
                            32'(want.byte_index));
                check_field("hop_channel", 32'(m_hop_channel), 32'(want.hop_channel),
                            32'(want.byte_index));
                check_field("last_byte", 32'(m_last_byte), 32'(want.last_byte),
                            32'(want.byte_index));
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_payload_fields();
        test_bind_flags();
        test_identity_change();
        test_random_traffic();
        test_steady_stream();
        wait_for_payloads();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("rc_hopping_packet_framer_top regression: pass");
        end else begin
            $display("rc_hopping_packet_framer_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: rc_hopping_packet_framer_top.f
src/rchpf_pkg.sv
src/rchpf_cell.sv
src/rchpf_hop_calc.sv
src/rc_hopping_packet_framer_top.sv
verif/rc_hopping_packet_framer_top_tb.sv
